// ===== rtl/spas_pkg.sv =====
package spas_pkg;

  // Fixed widths of the term fields on the ports.
  localparam int unsigned COEFF_W  = 32;
  localparam int unsigned EXP_IO_W = 16;
  localparam int unsigned OP_W     = 2;

  // Input opcodes.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_ADD    = 2'd2,
    OP_SUB    = 2'd3
  } opcode_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CALC,
    ST_FINISH
  } state_e;

endpackage

// ===== rtl/sparse_polynomial_add_sub.sv =====
// Sparse polynomial adder and subtractor.
// Input channel (in_valid_i / in_stall_o) carries one command per transfer:
// a load into term store A or B (coefficient and exponent), or a combine that
// merges both stores by descending exponent as A plus B or A minus B.
// Output channel (out_valid_o / out_stall_i) carries one result term per
// transfer, with last_term_o on the final one; an empty result gives a single
// transfer with term_valid_o low. overflow_o reports loads dropped because a
// store was full. After a combine both stores and the overflow flag are empty.
// A load is written into its store and the block is ready again at once. A
// combine of na and nb terms runs a fetch and a calc state per step (at most
// na+nb steps), then fetch and finish; each step reads one entry of each
// store through a registered read port, then the single shared adder and
// exponent comparator resolve it. One result is held back so that the last
// one can be marked. A stall on the output holds the output register and,
// once another result is ready, freezes the merge. in_stall_o is high for the
// whole combine. Reset clears the term counts, the flag and the sequencer;
// store contents are not cleared, only entries below the counts are read.
module sparse_polynomial_add_sub #(
  parameter int unsigned MAX_TERMS = 32,
  parameter int unsigned EXP_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic signed [31:0] term_coeff_i,
  input  logic [15:0] term_exponent_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] result_coeff_o,
  output logic [15:0] result_exponent_o,
  output logic        term_valid_o,
  output logic        last_term_o,
  output logic        overflow_o
);

  localparam int unsigned CntW   = $clog2(MAX_TERMS + 1);
  localparam int unsigned IdxW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CoeffW = spas_pkg::COEFF_W;
  localparam int unsigned ExpIoW = spas_pkg::EXP_IO_W;
  localparam logic [CntW-1:0] FullCnt = CntW'(MAX_TERMS);

  // Term stores.
  logic [CoeffW-1:0]    a_coeff_mem [MAX_TERMS];
  logic [EXP_WIDTH-1:0] a_exp_mem   [MAX_TERMS];
  logic [CoeffW-1:0]    b_coeff_mem [MAX_TERMS];
  logic [EXP_WIDTH-1:0] b_exp_mem   [MAX_TERMS];

  logic [CoeffW-1:0]    a_coeff_rd_q, b_coeff_rd_q;
  logic [EXP_WIDTH-1:0] a_exp_rd_q, b_exp_rd_q;

  spas_pkg::state_e state_q, state_d;
  logic [CntW-1:0] a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;
  logic [CntW-1:0] ia_q, ia_d, ib_q, ib_d;
  logic            dropped_q, dropped_d;
  logic            sub_q, sub_d;
  logic            pend_q, pend_d;
  logic [CoeffW-1:0]    pend_coeff_q, pend_coeff_d;
  logic [EXP_WIDTH-1:0] pend_exp_q, pend_exp_d;

  logic              out_valid_q, out_valid_d;
  logic [CoeffW-1:0] out_coeff_q, out_coeff_d;
  logic [ExpIoW-1:0] out_exp_q, out_exp_d;
  logic              out_tv_q, out_tv_d;
  logic              out_last_q, out_last_d;
  logic              out_ovf_q, out_ovf_d;

  logic                 in_accept, out_free, out_load;
  logic                 wr_a, wr_b;
  logic                 a_left, b_left, take_a, take_b;
  logic [CoeffW-1:0]    add_x, add_y, sum;
  logic [EXP_WIDTH-1:0] res_exp, in_exp;
  spas_pkg::opcode_e    op;

  assign op        = spas_pkg::opcode_e'(opcode_i);
  assign in_exp    = EXP_WIDTH'(term_exponent_i);
  assign in_accept = in_valid_i && (state_q == spas_pkg::ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;

  // Store writes during loads.
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      a_coeff_mem[a_cnt_q[IdxW-1:0]] <= term_coeff_i;
      a_exp_mem[a_cnt_q[IdxW-1:0]]   <= in_exp;
    end
    if (wr_b) begin
      b_coeff_mem[b_cnt_q[IdxW-1:0]] <= term_coeff_i;
      b_exp_mem[b_cnt_q[IdxW-1:0]]   <= in_exp;
    end
  end

  // Registered read of the current head of each store.
  always_ff @(posedge clk_i) begin
    a_coeff_rd_q <= a_coeff_mem[ia_q[IdxW-1:0]];
    a_exp_rd_q   <= a_exp_mem[ia_q[IdxW-1:0]];
    b_coeff_rd_q <= b_coeff_mem[ib_q[IdxW-1:0]];
    b_exp_rd_q   <= b_exp_mem[ib_q[IdxW-1:0]];
  end

  // Merge decision, shared exponent comparator and shared adder.
  assign a_left  = ia_q < a_cnt_q;
  assign b_left  = ib_q < b_cnt_q;
  assign take_a  = !b_left || (a_left && (a_exp_rd_q > b_exp_rd_q));
  assign take_b  = !take_a && (!a_left || (b_exp_rd_q > a_exp_rd_q));
  assign add_x   = take_b ? '0 : a_coeff_rd_q;
  assign add_y   = take_a ? '0 : b_coeff_rd_q;
  assign sum     = add_x + (sub_q ? ~add_y : add_y) + CoeffW'(sub_q);
  assign res_exp = take_b ? b_exp_rd_q : a_exp_rd_q;

  // Sequencer: next state, store updates and output loads.
  always_comb begin
    state_d      = state_q;
    a_cnt_d      = a_cnt_q;
    b_cnt_d      = b_cnt_q;
    ia_d         = ia_q;
    ib_d         = ib_q;
    dropped_d    = dropped_q;
    sub_d        = sub_q;
    pend_d       = pend_q;
    pend_coeff_d = pend_coeff_q;
    pend_exp_d   = pend_exp_q;
    wr_a         = 1'b0;
    wr_b         = 1'b0;
    out_load     = 1'b0;
    out_coeff_d  = pend_coeff_q;
    out_exp_d    = ExpIoW'(pend_exp_q);
    out_tv_d     = 1'b1;
    out_last_d   = 1'b0;
    out_ovf_d    = dropped_q;

    unique case (state_q)
      spas_pkg::ST_IDLE: begin
        if (in_accept) begin
          unique case (op)
            spas_pkg::OP_LOAD_A: begin
              if (a_cnt_q != FullCnt) begin
                wr_a    = 1'b1;
                a_cnt_d = a_cnt_q + CntW'(1);
              end else begin
                dropped_d = 1'b1;
              end
            end
            spas_pkg::OP_LOAD_B: begin
              if (b_cnt_q != FullCnt) begin
                wr_b    = 1'b1;
                b_cnt_d = b_cnt_q + CntW'(1);
              end else begin
                dropped_d = 1'b1;
              end
            end
            spas_pkg::OP_ADD, spas_pkg::OP_SUB: begin
              sub_d   = (op == spas_pkg::OP_SUB);
              ia_d    = '0;
              ib_d    = '0;
              pend_d  = 1'b0;
              state_d = spas_pkg::ST_FETCH;
            end
          endcase
        end
      end

      spas_pkg::ST_FETCH: begin
        state_d = (a_left || b_left) ? spas_pkg::ST_CALC : spas_pkg::ST_FINISH;
      end

      spas_pkg::ST_CALC: begin
        // Hold the step while a held-back result cannot move on.
        if (!((sum != '0) && pend_q && !out_free)) begin
          ia_d = take_b ? ia_q : ia_q + CntW'(1);
          ib_d = take_a ? ib_q : ib_q + CntW'(1);
          if (sum != '0) begin
            out_load     = pend_q;
            pend_d       = 1'b1;
            pend_coeff_d = sum;
            pend_exp_d   = res_exp;
          end
          state_d = spas_pkg::ST_FETCH;
        end
      end

      spas_pkg::ST_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last_d = 1'b1;
          if (!pend_q) begin
            out_coeff_d = '0;
            out_exp_d   = '0;
            out_tv_d    = 1'b0;
          end
          a_cnt_d   = '0;
          b_cnt_d   = '0;
          dropped_d = 1'b0;
          pend_d    = 1'b0;
          state_d   = spas_pkg::ST_IDLE;
        end
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spas_pkg::ST_IDLE;
      a_cnt_q     <= '0;
      b_cnt_q     <= '0;
      ia_q        <= '0;
      ib_q        <= '0;
      dropped_q   <= 1'b0;
      sub_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      a_cnt_q     <= a_cnt_d;
      b_cnt_q     <= b_cnt_d;
      ia_q        <= ia_d;
      ib_q        <= ib_d;
      dropped_q   <= dropped_d;
      sub_q       <= sub_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers for the held-back result and the output stage.
  always_ff @(posedge clk_i) begin
    pend_coeff_q <= pend_coeff_d;
    pend_exp_q   <= pend_exp_d;
    if (out_load) begin
      out_coeff_q <= out_coeff_d;
      out_exp_q   <= out_exp_d;
      out_tv_q    <= out_tv_d;
      out_last_q  <= out_last_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  assign in_stall_o        = (state_q != spas_pkg::ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign result_coeff_o    = out_coeff_q;
  assign result_exponent_o = out_exp_q;
  assign term_valid_o      = out_tv_q;
  assign last_term_o       = out_last_q;
  assign overflow_o        = out_ovf_q;

endmodule

// ===== rtl/spas_checker.sv =====
module spas_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  opcode_i,
  input logic [31:0] term_coeff_i,
  input logic [15:0] term_exponent_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] result_coeff_o,
  input logic [15:0] result_exponent_o,
  input logic        term_valid_o,
  input logic        last_term_o,
  input logic        overflow_o
);

  // A stalled result stays on the port unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_coeff_o) &&
      $stable(result_exponent_o) && $stable(term_valid_o) && $stable(last_term_o))
    else $error("stalled result changed");

  // The empty-result marker is always the last transfer and carries zeros.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !term_valid_o |-> last_term_o && (result_coeff_o == '0) &&
      (result_exponent_o == '0))
    else $error("malformed empty-result marker");

  // Real terms never carry a zero coefficient.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && term_valid_o |-> result_coeff_o != '0)
    else $error("zero coefficient emitted");

  // While a term that is not the last one is on the output, the combine is
  // still running, so the input side stays stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_term_o |-> in_stall_o)
    else $error("input accepted in the middle of a combine");

endmodule

bind sparse_polynomial_add_sub spas_checker u_spas_checker (.*);
